// File: rtl/core/sau_pkg.sv
// Package for the stack arithmetic unit: word and depth constants, command,
// status and action codes, and the cell control struct.
// No dependencies.
package sau_pkg;

    localparam int WORD_W  = 32;
    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_FEW   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_POP   = 2'd2;
    localparam logic [1:0] ACT_ARITH = 2'd3;

    typedef struct packed {
        logic take_up;
        logic take_down;
    } t_cell_ctl;

endpackage

// File: rtl/core/sau_cell.sv
// One stack entry: holds a word and takes the word of its upper or lower
// neighbor when told. Depends on sau_pkg.
module sau_cell (
    input  logic                     i_clk,
    input  sau_pkg::t_cell_ctl       i_ctl,
    input  logic [sau_pkg::WORD_W-1:0] i_up,
    input  logic [sau_pkg::WORD_W-1:0] i_down,
    output logic [sau_pkg::WORD_W-1:0] o_word
);

    logic [sau_pkg::WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_up) begin
            r_word <= i_up;
        end else if (i_ctl.take_down) begin
            r_word <= i_down;
        end
    end

    assign o_word = r_word;

endmodule

// File: rtl/core/sau_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sau_pkg.
module sau_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sau_pkg::WORD_W-1:0] i_dividend,
    input  logic [sau_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sau_pkg::WORD_W-1:0] o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [sau_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [sau_pkg::WORD_W-1:0]    r_rem;
    logic [sau_pkg::WORD_W-1:0]    r_quo;
    logic [sau_pkg::WORD_W-1:0]    r_dsr;
    logic [sau_pkg::WORD_W:0]      w_shift;
    logic [sau_pkg::WORD_W:0]      w_diff;
    logic                          w_fit;

    assign w_shift = {r_rem, r_quo[sau_pkg::WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_fit   = (w_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sau_pkg::DIV_CNT_W'(sau_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[sau_pkg::WORD_W-1:0] : w_shift[sau_pkg::WORD_W-1:0];
            r_quo <= {r_quo[sau_pkg::WORD_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/stack_arithmetic_unit_core.sv
// Stack arithmetic unit top level: command decode, sequencer, chain of stack
// cells and the output register. Depends on sau_pkg, sau_cell, sau_divider.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one command word
// with i_command and i_push_value; the output channel (o_out_valid /
// i_out_ready) returns one result word per command with o_status, o_top_value
// and o_depth. The stack is a row of DEPTH cells, top at cell 0; a push shifts
// every cell down by one, a pop shifts every cell up, and an arithmetic
// command loads the result into cell 0 while the rest shift up.
// From accept, a command passes through the execute and write states; a divide
// that is not an error also waits in the divide state until the divider, which
// retires one quotient bit per cycle, is done. One command is in flight at a
// time; o_in_ready rises in the cycle after the previous result is loaded.
// The result sits in an output register; if the receiver stalls, the unit
// holds in its write state with the stack untouched until the slot frees.
// Reset empties the stack (depth zero) and drops any pending result; entry
// contents are not cleared.
module stack_arithmetic_unit_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sau_pkg::CMD_W-1:0]   i_command,
    input  logic [sau_pkg::WORD_W-1:0]  i_push_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sau_pkg::STAT_W-1:0]  o_status,
    output logic [sau_pkg::WORD_W-1:0]  o_top_value,
    output logic [sau_pkg::CNT_W-1:0]   o_depth
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [sau_pkg::CMD_W-1:0]     r_cmd;
    logic [sau_pkg::WORD_W-1:0]    r_val;
    logic [sau_pkg::WORD_W-1:0]    r_res;
    logic [sau_pkg::STAT_W-1:0]    r_stat;
    logic [1:0]                    r_act;
    logic [sau_pkg::CNT_W-1:0]     r_count;
    logic [sau_pkg::CNT_W-1:0]     n_count;
    logic                          r_out_valid;
    logic [sau_pkg::STAT_W-1:0]    r_out_stat;
    logic [sau_pkg::WORD_W-1:0]    r_out_top;
    logic [sau_pkg::CNT_W-1:0]     r_out_depth;

    logic [sau_pkg::WORD_W-1:0]    w_cell [sau_pkg::DEPTH];
    logic [sau_pkg::WORD_W-1:0]    w_new_top;
    logic [sau_pkg::WORD_W-1:0]    w_top_next;
    logic [sau_pkg::WORD_W-1:0]    w_a;
    logic [sau_pkg::WORD_W-1:0]    w_b;
    logic [sau_pkg::WORD_W-1:0]    w_prod;
    logic [sau_pkg::WORD_W-1:0]    w_quo;
    logic                          w_div_done;
    logic                          w_div_start;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_commit;
    logic [sau_pkg::STAT_W-1:0]    w_stat;
    logic [1:0]                    w_act;
    sau_pkg::t_cell_ctl            w_ctl_top;
    sau_pkg::t_cell_ctl            w_ctl_rest;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_WRITE) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_b        = w_cell[0];
    assign w_a        = w_cell[1];
    assign w_prod     = w_a * w_b;

    always_comb begin
        w_stat = sau_pkg::ST_OK;
        w_act  = sau_pkg::ACT_NONE;
        unique case (r_cmd) inside
            sau_pkg::CMD_PUSH: begin
                if (r_count >= sau_pkg::CNT_W'(sau_pkg::DEPTH)) begin
                    w_stat = sau_pkg::ST_FULL;
                end else begin
                    w_act = sau_pkg::ACT_PUSH;
                end
            end
            sau_pkg::CMD_POP: begin
                if (r_count == '0) begin
                    w_stat = sau_pkg::ST_POP_EMPTY;
                end else begin
                    w_act = sau_pkg::ACT_POP;
                end
            end
            sau_pkg::CMD_ADD, sau_pkg::CMD_SUB, sau_pkg::CMD_DIV, sau_pkg::CMD_MUL: begin
                if (r_count < sau_pkg::CNT_W'(2)) begin
                    w_stat = sau_pkg::ST_TOO_FEW;
                end else if (r_cmd == sau_pkg::CMD_DIV && w_b == '0) begin
                    w_stat = sau_pkg::ST_DIV_ZERO;
                end else begin
                    w_act = sau_pkg::ACT_ARITH;
                end
            end
            default: begin
                w_stat = sau_pkg::ST_OK;
                w_act  = sau_pkg::ACT_NONE;
            end
        endcase
    end

    assign w_div_start = (r_state == S_EXEC) && (r_cmd == sau_pkg::CMD_DIV)
                         && (w_act == sau_pkg::ACT_ARITH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = w_div_start ? S_DIV : S_WRITE;
            S_DIV:   if (w_div_done) n_state = S_WRITE;
            S_WRITE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_val <= i_push_value;
        end
        if (r_state == S_EXEC) begin
            r_stat <= w_stat;
            r_act  <= w_act;
            case (r_cmd)
                sau_pkg::CMD_ADD: r_res <= w_a + w_b;
                sau_pkg::CMD_SUB: r_res <= w_a - w_b;
                default:          r_res <= w_prod;
            endcase
        end else if (r_state == S_DIV && w_div_done) begin
            r_res <= w_quo;
        end
    end

    sau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_a),
        .i_divisor  (w_b),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        w_ctl_top  = '0;
        w_ctl_rest = '0;
        n_count    = r_count;
        w_new_top  = r_res;
        w_top_next = w_cell[0];
        case (r_act)
            sau_pkg::ACT_PUSH: begin
                w_ctl_top  = '{take_up: 1'b1, take_down: 1'b0};
                w_ctl_rest = '{take_up: 1'b1, take_down: 1'b0};
                n_count    = r_count + 1'b1;
                w_new_top  = r_val;
                w_top_next = r_val;
            end
            sau_pkg::ACT_POP: begin
                w_ctl_top  = '{take_up: 1'b0, take_down: 1'b1};
                w_ctl_rest = '{take_up: 1'b0, take_down: 1'b1};
                n_count    = r_count - 1'b1;
                w_top_next = w_cell[1];
            end
            sau_pkg::ACT_ARITH: begin
                w_ctl_top  = '{take_up: 1'b1, take_down: 1'b0};
                w_ctl_rest = '{take_up: 1'b0, take_down: 1'b1};
                n_count    = r_count - 1'b1;
                w_top_next = r_res;
            end
            default: begin
                w_ctl_top  = '0;
                w_ctl_rest = '0;
            end
        endcase
        if (!w_commit) begin
            w_ctl_top  = '0;
            w_ctl_rest = '0;
        end
    end

    for (genvar g = 0; g < sau_pkg::DEPTH; g++) begin : g_cell
        sau_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  ((g == 0) ? w_ctl_top : w_ctl_rest),
            .i_up   ((g == 0) ? w_new_top : w_cell[(g == 0) ? 0 : g - 1]),
            .i_down (w_cell[(g == sau_pkg::DEPTH - 1) ? g : g + 1]),
            .o_word (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_stat  <= r_stat;
            r_out_depth <= n_count;
            r_out_top   <= (n_count == '0) ? '0 : w_top_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_stat;
    assign o_top_value = r_out_top;
    assign o_depth     = r_out_depth;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_depth <= sau_pkg::CNT_W'(sau_pkg::DEPTH))
        else $error("depth beyond stack size");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth == '0 |-> o_top_value == '0)
        else $error("nonzero top on empty stack");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second command accepted while busy");

    a_div_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

endmodule

// File: tb/stack_arithmetic_unit_core_test.sv
// Testbench for stack_arithmetic_unit_core: a directed table, then depth-steered random
// commands under four idle/stall phases, each result word checked against its typed table
// row or else a stack predictor. Depends on sau_pkg and the stack_arithmetic_unit_core RTL.
module stack_arithmetic_unit_core_test;
    import sau_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam int RAND_ITEMS  = 1450;
    localparam int PHASE_ITEMS = 90;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] top;
        logic [CNT_W-1:0]  depth;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] val;
        logic              typed;
        result_t           want;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{CMD_POP,   32'h0000_0000, 1'b1, '{ST_POP_EMPTY, 32'h0000_0000, 7'd0}},
        '{CMD_ADD,   32'h1234_5678, 1'b1, '{ST_TOO_FEW,   32'h0000_0000, 7'd0}},
        '{CMD_DIV,   32'h0000_0000, 1'b1, '{ST_TOO_FEW,   32'h0000_0000, 7'd0}},
        '{CMD_SUB,   32'hFFFF_FFFF, 1'b1, '{ST_TOO_FEW,   32'h0000_0000, 7'd0}},
        '{CMD_PUSH,  32'h0000_0000, 1'b1, '{ST_OK,        32'h0000_0000, 7'd1}},
        '{CMD_DIV,   32'hDEAD_BEEF, 1'b1, '{ST_TOO_FEW,   32'h0000_0000, 7'd1}},
        '{CMD_PUSH,  32'hFFFF_FFFF, 1'b1, '{ST_OK,        32'hFFFF_FFFF, 7'd2}},
        '{CMD_ADD,   32'h0000_0000, 1'b1, '{ST_OK,        32'hFFFF_FFFF, 7'd1}},
        '{CMD_PUSH,  32'h0000_0001, 1'b1, '{ST_OK,        32'h0000_0001, 7'd2}},
        '{CMD_ADD,   32'hFFFF_FFFF, 1'b1, '{ST_OK,        32'h0000_0000, 7'd1}},
        '{CMD_PUSH,  32'h0000_0000, 1'b1, '{ST_OK,        32'h0000_0000, 7'd2}},
        '{CMD_DIV,   32'h0000_0001, 1'b1, '{ST_DIV_ZERO,  32'h0000_0000, 7'd2}},
        '{CMD_POP,   32'h5555_5555, 1'b1, '{ST_OK,        32'h0000_0000, 7'd1}},
        '{CMD_PUSH,  32'h0000_0005, 1'b0, '0},
        '{CMD_SUB,   32'h0000_0000, 1'b0, '0},
        '{CMD_PUSH,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_MUL,   32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_PUSH,  32'h0000_0007, 1'b0, '0},
        '{CMD_DIV,   32'h0000_0000, 1'b0, '0},
        '{CMD_RSVD6, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_RSVD7, 32'h5555_5555, 1'b0, '0},
        '{CMD_PUSH,  32'h8000_0000, 1'b0, '0},
        '{CMD_PUSH,  32'h0000_0002, 1'b0, '0},
        '{CMD_MUL,   32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_POP,   32'h0000_0000, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_command = CMD_PUSH;
    logic [WORD_W-1:0] i_push_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [WORD_W-1:0] o_top_value;
    logic [CNT_W-1:0]  o_depth;

    logic              word_typed = 1'b0;
    result_t           word_want = '0;

    logic [WORD_W-1:0] stk_words [DEPTH];
    int                stk_count = 0;
    result_t           pending_results [$];
    int                err_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    stack_arithmetic_unit_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic result_t stack_apply(input logic [CMD_W-1:0] cmd,
                                            input logic [WORD_W-1:0] val);
        result_t           r;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] q;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (stk_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stk_words[stk_count] = val;
                    stk_count++;
                end
            end
            CMD_POP: begin
                if (stk_count == 0) r.status = ST_POP_EMPTY;
                else stk_count--;
            end
            CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
                if (stk_count < 2) begin
                    r.status = ST_TOO_FEW;
                end else begin
                    b = stk_words[stk_count-1];
                    a = stk_words[stk_count-2];
                    if (cmd == CMD_DIV && b == '0) begin
                        r.status = ST_DIV_ZERO;
                    end else begin
                        case (cmd)
                            CMD_ADD: q = a + b;
                            CMD_SUB: q = a - b;
                            CMD_DIV: q = a / b;
                            default: q = a * b;
                        endcase
                        stk_count--;
                        stk_words[stk_count-1] = q;
                    end
                end
            end
            default: ;
        endcase
        r.top   = (stk_count > 0) ? stk_words[stk_count-1] : '0;
        r.depth = stk_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return $urandom_range(3);
        if (roll < 35) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                             input logic typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        word_typed   <= typed;
        word_want    <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        result_t predicted;
        result_t want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted = stack_apply(i_command, i_push_value);
                pending_results.push_back(word_typed ? word_want : predicted);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_error("result word with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        flag_error($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_top_value !== want.top)
                        flag_error($sformatf("top %h, want %h", o_top_value, want.top));
                    if (o_depth !== want.depth)
                        flag_error($sformatf("depth %0d, want %0d", o_depth, want.depth));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int               n;
        int               roll;
        int               depth_guess;
        bit               rising;
        logic [CMD_W-1:0] cmd;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            send_word(DIRECTED[n].cmd, DIRECTED[n].val, DIRECTED[n].typed, DIRECTED[n].want);
        end

        depth_guess = 0;
        rising = 1'b1;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                case ((n / PHASE_ITEMS) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                    default: begin send_idle_pct = 7; recv_stall_pct = 7; end
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 2) begin
                cmd = CMD_RSVD6;
            end else if (roll < 3) begin
                cmd = CMD_RSVD7;
            end else if (roll < (rising ? 68 : 28)) begin
                cmd = CMD_PUSH;
            end else begin
                case ($urandom_range(4))
                    0: cmd = CMD_POP;
                    1: cmd = CMD_ADD;
                    2: cmd = CMD_SUB;
                    3: cmd = CMD_DIV;
                    default: cmd = CMD_MUL;
                endcase
            end
            case (cmd)
                CMD_PUSH: if (depth_guess < DEPTH) depth_guess++;
                CMD_POP: if (depth_guess > 0) depth_guess--;
                CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: if (depth_guess >= 2) depth_guess--;
                default: ;
            endcase
            // hold at the bounds for a few words so full and empty errors show up
            if (rising && depth_guess == DEPTH && $urandom_range(99) < 30)
                rising = 1'b0;
            else if (!rising && $urandom_range(99) < ((depth_guess == 0) ? 30 : 3))
                rising = 1'b1;
            send_word(cmd, rand_word(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) flag_error("results still pending at end");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sau_pkg.sv
rtl/core/sau_cell.sv
rtl/core/sau_divider.sv
rtl/core/stack_arithmetic_unit_core.sv
tb/stack_arithmetic_unit_core_test.sv
